// ===== rtl/core/gmmc_pkg.sv =====
// ----------------------------------------------------------------------------
// gmmc_pkg
// Shared types and codes for the gate motor move controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gmmc_pkg;

  localparam int TIME_BITS = 32;

  localparam int POWER_W = 14;
  localparam int STEP_W  = 10;
  localparam int ACCEL_W = 20;

  // reciprocal of 1000 scaled by 2^RECIP_SHIFT, rounded up
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 11;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 11'd1049;
  localparam int PROD_W = ACCEL_W + RECIP_W;
  localparam int QUOT_W = PROD_W - RECIP_SHIFT;

  localparam logic [POWER_W-1:0] POWER_FULL = 14'd10000;
  localparam logic [QUOT_W-1:0]  STEP_MAX   = 11'd1023;
  localparam logic [9:0]         STEP_DIV   = 10'd1000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL       = 2'd1;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  localparam logic [1:0] TGT_OPEN  = 2'd0;
  localparam logic [1:0] TGT_CLOSE = 2'd1;

  localparam logic [1:0] MOT_STOPPED = 2'd0;
  localparam logic [1:0] MOT_OPENING = 2'd1;
  localparam logic [1:0] MOT_CLOSING = 2'd2;

  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_OCUR    = 2'd1;
  localparam logic [1:0] RES_TIMEOUT = 2'd2;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_OCUR    = 3'd1;
  localparam logic [2:0] EV_OPENED  = 3'd2;
  localparam logic [2:0] EV_CLOSED  = 3'd3;
  localparam logic [2:0] EV_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [1:0]           motion;
    logic [1:0]           result;
    logic                 open_rep;
    logic                 close_rep;
    logic [POWER_W-1:0]   drive;
    logic [POWER_W-1:0]   target;
    logic [STEP_W-1:0]    step;
    logic [TIME_BITS-1:0] limit;
    logic [TIME_BITS-1:0] elapsed;
    logic                 leave;
  } gmmc_state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         target;
    logic [POWER_W-1:0] request_power;
    logic [31:0]        timeout_ticks;
    logic               off_sensor_mode;
    logic               sensor_open;
    logic               sensor_close;
    logic               overcurrent;
  } gmmc_item_t;

  typedef struct packed {
    logic [1:0]         motion;
    logic [1:0]         motion_result;
    logic [2:0]         event_res;
    logic               stop_request;
    logic               power_update;
    logic [POWER_W-1:0] power_level;
  } gmmc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/gmmc_step.sv =====
// ----------------------------------------------------------------------------
// gmmc_step
// Next state and result word for one request or tick, plus ramp step decode.
// ----------------------------------------------------------------------------
`default_nettype none

module gmmc_step (
  input  gmmc_pkg::gmmc_state_t            st,
  input  gmmc_pkg::gmmc_item_t             item,
  input  logic [gmmc_pkg::POWER_W-1:0]     start_power,
  input  logic [gmmc_pkg::ACCEL_W-1:0]     accel,
  input  logic [gmmc_pkg::PROD_W-1:0]      accel_prod,
  output gmmc_pkg::gmmc_state_t            st_nxt,
  output gmmc_pkg::gmmc_result_t           res
);
  import gmmc_pkg::*;

  logic [QUOT_W-1:0]    quot_est;
  logic [QUOT_W+9:0]    quot_back;
  logic [QUOT_W-1:0]    quot;
  logic [STEP_W-1:0]    step_dec;
  logic [POWER_W-1:0]   tgt_clamp;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic [2:0]           ev;
  logic                 stop;
  logic                 pupd;

  // estimate is exact or one high; pull back when it overshoots
  always_comb begin
    quot_est  = accel_prod[PROD_W-1:RECIP_SHIFT];
    quot_back = quot_est * STEP_DIV;
    if (quot_back > {{(QUOT_W+10-ACCEL_W){1'b0}}, accel}) begin
      quot = quot_est - 1'b1;
    end else begin
      quot = quot_est;
    end
    step_dec = (quot > STEP_MAX) ? STEP_MAX[STEP_W-1:0] : quot[STEP_W-1:0];
  end

  always_comb begin
    st_nxt      = st;
    ev          = EV_NONE;
    stop        = 1'b0;
    pupd        = 1'b0;
    tgt_clamp   = (item.request_power > POWER_FULL) ? POWER_FULL : item.request_power;
    elapsed_inc = st.elapsed + 1'b1;
    priority if (item.kind == KIND_MOVE) begin
      if (item.target == TGT_OPEN) begin
        st_nxt.open_rep = 1'b0;
        st_nxt.motion   = MOT_OPENING;
      end else if (item.target == TGT_CLOSE) begin
        st_nxt.close_rep = 1'b0;
        st_nxt.motion    = MOT_CLOSING;
      end
      st_nxt.target  = tgt_clamp;
      st_nxt.drive   = (start_power > tgt_clamp) ? tgt_clamp : start_power;
      st_nxt.result  = RES_OK;
      st_nxt.limit   = item.timeout_ticks[TIME_BITS-1:0];
      st_nxt.elapsed = '0;
      st_nxt.leave   = item.off_sensor_mode;
      st_nxt.step    = step_dec;
    end else if (item.kind == KIND_STOP) begin
      stop          = 1'b1;
      st_nxt.motion = MOT_STOPPED;
    end else if (item.kind == KIND_TICK) begin
      if (item.overcurrent) begin
        stop          = 1'b1;
        st_nxt.motion = MOT_STOPPED;
        if (st.result != RES_OCUR) begin
          st_nxt.result = RES_OCUR;
          ev            = EV_OCUR;
        end
      end
      if (st_nxt.motion == MOT_OPENING) begin
        if (!item.sensor_close && st.leave) begin
          stop          = 1'b1;
          st_nxt.motion = MOT_STOPPED;
        end else if (item.sensor_open) begin
          stop          = 1'b1;
          st_nxt.motion = MOT_STOPPED;
          if (!st.open_rep) begin
            st_nxt.open_rep = 1'b1;
            ev              = EV_OPENED;
          end
        end
      end else if (st_nxt.motion == MOT_CLOSING) begin
        if (item.sensor_close || (!item.sensor_open && st.leave)) begin
          stop          = 1'b1;
          st_nxt.motion = MOT_STOPPED;
          if (!st.close_rep) begin
            st_nxt.close_rep = 1'b1;
            ev               = EV_CLOSED;
          end
        end
      end
      if (st_nxt.motion != MOT_STOPPED) begin
        st_nxt.elapsed = elapsed_inc;
        if (elapsed_inc >= st.limit) begin
          stop          = 1'b1;
          st_nxt.motion = MOT_STOPPED;
          st_nxt.result = RES_TIMEOUT;
          ev            = EV_TIMEOUT;
        end else if (st.drive < st.target) begin
          // ramp may overshoot the target; wrap at the register width
          st_nxt.drive = st.drive + {{(POWER_W-STEP_W){1'b0}}, st.step};
          pupd         = 1'b1;
        end
      end
    end else begin
      // unused kind: hold everything, no strobes
      st_nxt = st;
    end

    res.motion        = st_nxt.motion;
    res.motion_result = st_nxt.result;
    res.event_res     = ev;
    res.stop_request  = stop;
    res.power_update  = pupd;
    res.power_level   = st_nxt.drive;
  end

endmodule

`default_nettype wire

// ===== rtl/core/gate_motor_move_controller.sv =====
// ----------------------------------------------------------------------------
// gate_motor_move_controller
// Open/close motion control for a sliding gate motor.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one word per tick, move request or stop command (kind selects).
//   out_*  : one result word per input word, in order: motion state, result
//            code, event, stop and power-update strobes, drive power.
//   cfg_*  : register writes (0 start power, 1 acceleration); always ready.
//            Write only while no word is in flight.
// An accepted word passes the input register, then the step logic into the
// result register, which drives out_valid.
// Throughput is one word per cycle while out_ready stays high.
// When out_ready is low the result word holds, the input register still
// takes one more word, then in_ready drops until the result is taken.
// Synchronous reset clears all motion state, the config registers and both valid
// flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module gate_motor_move_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic [1:0]                         in_target,
  input  logic [gmmc_pkg::POWER_W-1:0]       in_request_power,
  input  logic [31:0]                        in_timeout_ticks,
  input  logic                               in_off_sensor_mode,
  input  logic                               in_sensor_open,
  input  logic                               in_sensor_close,
  input  logic                               in_overcurrent,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_motion,
  output logic [1:0]                         out_motion_result,
  output logic [2:0]                         out_event_res,
  output logic                               out_stop_request,
  output logic                               out_power_update,
  output logic [gmmc_pkg::POWER_W-1:0]       out_power_level,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gmmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gmmc_pkg::ACCEL_W-1:0]       cfg_data
);
  import gmmc_pkg::*;

  gmmc_state_t        st_r;
  gmmc_state_t        st_nxt;
  gmmc_item_t         item_r;
  gmmc_result_t       res_nxt;
  gmmc_result_t       res_r;
  logic               item_valid_r;
  logic               out_valid_r;
  logic               advance;
  logic [POWER_W-1:0] start_power_r;
  logic [ACCEL_W-1:0] accel_r;
  logic [PROD_W-1:0]  accel_prod_r;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_power_r <= '0;
      accel_r       <= '0;
      accel_prod_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_START_POWER) begin
        start_power_r <= cfg_data[POWER_W-1:0];
      end else if (cfg_index == CFG_ACCEL) begin
        accel_r      <= cfg_data;
        // reciprocal product for the ramp step, settled before any move word
        accel_prod_r <= cfg_data * RECIP_1000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind            <= in_kind;
      item_r.target          <= in_target;
      item_r.request_power   <= in_request_power;
      item_r.timeout_ticks   <= in_timeout_ticks;
      item_r.off_sensor_mode <= in_off_sensor_mode;
      item_r.sensor_open     <= in_sensor_open;
      item_r.sensor_close    <= in_sensor_close;
      item_r.overcurrent     <= in_overcurrent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  gmmc_step u_step (
    .st          (st_r),
    .item        (item_r),
    .start_power (start_power_r),
    .accel       (accel_r),
    .accel_prod  (accel_prod_r),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motion        = res_r.motion;
  assign out_motion_result = res_r.motion_result;
  assign out_event_res     = res_r.event_res;
  assign out_stop_request  = res_r.stop_request;
  assign out_power_update  = res_r.power_update;
  assign out_power_level   = res_r.power_level;

endmodule

`default_nettype wire

// ===== tb/gate_motor_move_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_motor_move_controller_tb
// Self-checking bench for the gate motor move controller. A behavioural copy
// of the controller runs beside the block: every input word taken by the
// block steps that copy, and every result word is checked field by field
// against the oldest prediction. Stimulus is a short directed list, then
// move requests followed by tick runs that imitate the gate reaching or
// leaving its sensors, mixed with stops, overcurrent and random noise words.
// Both sides idle and stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------

module gate_motor_move_controller_tb;
  import gmmc_pkg::*;

  localparam logic [1:0]  KIND_SPARE  = 2'd3;
  localparam logic [1:0]  TGT_KEEP    = 2'd2;
  localparam logic [1:0]  TGT_SPARE   = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;

  // --------------------------------------------------------------------------
  // Behavioural copy of the controller plus the queue of predicted results
  // --------------------------------------------------------------------------
  class motion_ledger;
    logic [POWER_W-1:0] start_pow;
    logic [ACCEL_W-1:0] accel;
    gmmc_state_t        st;
    gmmc_result_t       due[$];
    int unsigned        mismatches;

    function new();
      start_pow  = '0;
      accel      = '0;
      st         = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ACCEL_W-1:0] data);
      if (idx == CFG_START_POWER) begin
        start_pow = data[POWER_W-1:0];
      end else if (idx == CFG_ACCEL) begin
        accel = data;
      end
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // Advance the copy by one accepted input word and queue the result.
    function void take_word(gmmc_item_t w);
      gmmc_result_t       r;
      logic [ACCEL_W-1:0] q;
      r = '0;
      r.event_res = EV_NONE;
      case (w.kind)
        KIND_MOVE: begin
          if (w.target == TGT_OPEN) begin
            st.open_rep = 1'b0;
            st.motion   = MOT_OPENING;
          end else if (w.target == TGT_CLOSE) begin
            st.close_rep = 1'b0;
            st.motion    = MOT_CLOSING;
          end
          st.target  = (w.request_power > POWER_FULL) ? POWER_FULL : w.request_power;
          st.drive   = (start_pow > st.target) ? st.target : start_pow;
          st.result  = RES_OK;
          st.limit   = w.timeout_ticks[TIME_BITS-1:0];
          st.elapsed = '0;
          st.leave   = w.off_sensor_mode;
          q = accel / STEP_DIV;
          st.step = (q > STEP_MAX) ? STEP_MAX[STEP_W-1:0] : q[STEP_W-1:0];
        end
        KIND_STOP: begin
          r.stop_request = 1'b1;
          st.motion      = MOT_STOPPED;
        end
        KIND_TICK: begin
          if (w.overcurrent) begin
            r.stop_request = 1'b1;
            st.motion      = MOT_STOPPED;
            if (st.result != RES_OCUR) begin
              st.result   = RES_OCUR;
              r.event_res = EV_OCUR;
            end
          end
          if (st.motion == MOT_OPENING) begin
            // opening in off-sensor mode ends once the close sensor drops
            if (!w.sensor_close && st.leave) begin
              r.stop_request = 1'b1;
              st.motion      = MOT_STOPPED;
            end else if (w.sensor_open) begin
              r.stop_request = 1'b1;
              st.motion      = MOT_STOPPED;
              if (!st.open_rep) begin
                st.open_rep = 1'b1;
                r.event_res = EV_OPENED;
              end
            end
          end else if (st.motion == MOT_CLOSING) begin
            if (w.sensor_close || (!w.sensor_open && st.leave)) begin
              r.stop_request = 1'b1;
              st.motion      = MOT_STOPPED;
              if (!st.close_rep) begin
                st.close_rep = 1'b1;
                r.event_res  = EV_CLOSED;
              end
            end
          end
          if (st.motion != MOT_STOPPED) begin
            st.elapsed = st.elapsed + 1'b1;
            if (st.elapsed >= st.limit) begin
              r.stop_request = 1'b1;
              st.motion      = MOT_STOPPED;
              st.result      = RES_TIMEOUT;
              r.event_res    = EV_TIMEOUT;
            end else if (st.drive < st.target) begin
              // ramp may overshoot the target and the step may be zero
              st.drive       = st.drive + st.step;
              r.power_update = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.motion        = st.motion;
      r.motion_result = st.result;
      r.power_level   = st.drive;
      due.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        mismatches++;
        $display("%0t  %s mismatch: expected %0d, actual %0d", $time, field, want_v,
                 got_v);
      end
    endfunction

    function void check_word(gmmc_result_t got);
      gmmc_result_t want;
      if (due.size() == 0) begin
        mismatches++;
        $display("%0t  result word with nothing pending: expected none, actual %h",
                 $time, got);
        return;
      end
      want = due.pop_front();
      compare("motion",        want.motion,        got.motion);
      compare("motion_result", want.motion_result, got.motion_result);
      compare("event_res",     want.event_res,     got.event_res);
      compare("stop_request",  want.stop_request,  got.stop_request);
      compare("power_update",  want.power_update,  got.power_update);
      compare("power_level",   want.power_level,   got.power_level);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  gmmc_item_t           cur_word  = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ACCEL_W-1:0]   cfg_data  = '0;

  logic               in_ready;
  logic               out_valid;
  logic               cfg_ready;
  logic [1:0]         out_motion;
  logic [1:0]         out_motion_result;
  logic [2:0]         out_event_res;
  logic               out_stop_request;
  logic               out_power_update;
  logic [POWER_W-1:0] out_power_level;
  gmmc_result_t       seen;

  bit           idle_on      = 1'b1;
  int unsigned  stall_left   = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  words_sent   = 0;
  motion_ledger book;

  assign seen = {out_motion, out_motion_result, out_event_res, out_stop_request,
                 out_power_update, out_power_level};

  gate_motor_move_controller i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (cur_word.kind),
    .in_target          (cur_word.target),
    .in_request_power   (cur_word.request_power),
    .in_timeout_ticks   (cur_word.timeout_ticks),
    .in_off_sensor_mode (cur_word.off_sensor_mode),
    .in_sensor_open     (cur_word.sensor_open),
    .in_sensor_close    (cur_word.sensor_close),
    .in_overcurrent     (cur_word.overcurrent),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_motion         (out_motion),
    .out_motion_result  (out_motion_result),
    .out_event_res      (out_event_res),
    .out_stop_request   (out_stop_request),
    .out_power_update   (out_power_update),
    .out_power_level    (out_power_level),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor, result-side stalls and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        book.set_reg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        book.take_word(cur_word);
      end
      if (out_valid && out_ready) begin
        book.check_word(seen);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t  no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic gmmc_item_t mk(logic [1:0] kind, logic [1:0] dir,
                                    logic [POWER_W-1:0] pow, logic [31:0] tmo,
                                    bit mode, bit s_open, bit s_close, bit ocur);
    gmmc_item_t w;
    w.kind            = kind;
    w.target          = dir;
    w.request_power   = pow;
    w.timeout_ticks   = tmo;
    w.off_sensor_mode = mode;
    w.sensor_open     = s_open;
    w.sensor_close    = s_close;
    w.overcurrent     = ocur;
    return w;
  endfunction

  function automatic gmmc_item_t random_word();
    gmmc_item_t w;
    w.kind            = 2'($urandom_range(0, 3));
    w.target          = 2'($urandom_range(0, 3));
    w.request_power   = POWER_W'($urandom);
    w.timeout_ticks   = $urandom;
    w.off_sensor_mode = 1'($urandom);
    w.sensor_open     = 1'($urandom);
    w.sensor_close    = 1'($urandom);
    w.overcurrent     = 1'($urandom);
    return w;
  endfunction

  function automatic gmmc_item_t random_move();
    gmmc_item_t w;
    w = random_word();
    w.kind = KIND_MOVE;
    if ($urandom_range(0, 9) < 8) begin
      w.target = $urandom_range(0, 1) ? TGT_CLOSE : TGT_OPEN;
    end else begin
      w.target = $urandom_range(0, 1) ? TGT_KEEP : TGT_SPARE;
    end
    case ($urandom_range(0, 3))
      0: w.request_power = POWER_W'($urandom);
      1: w.request_power = POWER_W'($urandom_range(9990, 10010));
      2: w.request_power = POWER_W'($urandom_range(0, 2000));
      default: w.request_power = POWER_W'($urandom_range(0, 10000));
    endcase
    case ($urandom_range(0, 9))
      0: w.timeout_ticks = '0;
      1: w.timeout_ticks = $urandom;
      2: w.timeout_ticks = '1;
      default: w.timeout_ticks = $urandom_range(1, 40);
    endcase
    w.off_sensor_mode = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  // Caller stands at a falling edge; returns at the falling edge after the take.
  task automatic send_word(input gmmc_item_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cur_word <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic configure(input logic [ACCEL_W-1:0] sp, input logic [ACCEL_W-1:0] acc);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_START_POWER;
    cfg_data  <= sp;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_ACCEL;
    cfg_data  <= acc;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One move request, then a run of ticks shaped like real gate travel.
  task automatic run_sequence();
    gmmc_item_t  w;
    gmmc_item_t  mv;
    int unsigned len;
    int unsigned arrive;
    int unsigned hold;
    bit          opening;
    mv = random_move();
    send_word(mv);
    if (mv.target == TGT_OPEN || mv.target == TGT_CLOSE) begin
      opening = (mv.target == TGT_OPEN);
    end else begin
      opening = 1'($urandom);
    end
    len    = $urandom_range(1, 40);
    arrive = $urandom_range(2, 45);
    hold   = $urandom_range(0, 4);
    for (int i = 0; i < len; i++) begin
      w = random_word();
      w.kind = KIND_TICK;
      if (mv.off_sensor_mode) begin
        // sit on the start sensor for a while, then leave it
        w.sensor_open  = !opening && (i < hold);
        w.sensor_close = opening && (i < hold);
      end else begin
        w.sensor_open  = opening && (i >= arrive);
        w.sensor_close = !opening && (i >= arrive);
      end
      if ($urandom_range(0, 19) == 0) w.sensor_open = ~w.sensor_open;
      if ($urandom_range(0, 19) == 0) w.sensor_close = ~w.sensor_close;
      w.overcurrent = ($urandom_range(0, 39) == 0);
      if ($urandom_range(0, 49) == 0) w.kind = KIND_STOP;
      send_word(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned        goal;
    logic [ACCEL_W-1:0] sp;
    logic [ACCEL_W-1:0] acc;
    book = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // ramp of 250 per tick from 15.00 %
    configure(20'd1500, 20'd250000);
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 1));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 1));
    send_word(mk(KIND_SPARE, TGT_SPARE, '1, '1, 1, 1, 1, 1));
    send_word(mk(KIND_MOVE, TGT_OPEN, '1, '1, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 1, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 1, 0, 0));
    send_word(mk(KIND_MOVE, TGT_KEEP, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_MOVE, TGT_CLOSE, 14'd5000, '0, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_MOVE, TGT_CLOSE, POWER_FULL, 32'd3, 1, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 1, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_MOVE, TGT_OPEN, 14'd8000, 32'd100, 1, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 1, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_MOVE, TGT_SPARE, 14'd3000, 32'd50, 0, 0, 0, 0));
    send_word(mk(KIND_STOP, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    settle();

    // zero step: power stays put but the update strobe still fires
    configure('0, '0);
    send_word(mk(KIND_MOVE, TGT_OPEN, 14'd100, 32'd10, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    settle();

    // saturated step: start lowered to target, then overshoot past full
    configure(20'd9500, '1);
    send_word(mk(KIND_MOVE, TGT_OPEN, 14'd200, 32'd10, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_MOVE, TGT_CLOSE, '1, 32'd10, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    send_word(mk(KIND_TICK, TGT_OPEN, '0, '0, 0, 0, 0, 0));
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin sp = '0;        acc = 20'd1000000; end
        1: begin sp = 20'd10000; acc = '0;          end
        2: begin sp = $urandom_range(0, 10000); acc = $urandom_range(0, 1000000); end
        3: begin sp = '1;        acc = $urandom_range(0, 1048575); end
        4: begin sp = $urandom_range(0, 10000); acc = 20'd999; end
        default: begin sp = $urandom_range(0, 10000); acc = $urandom_range(0, 1000000); end
      endcase
      configure(sp, acc);
      if (p == 5) idle_on <= 1'b0;
      goal = words_sent + 220;
      while (words_sent < goal) begin
        if (p != 5 && $urandom_range(0, 29) == 0) idle_on <= ~idle_on;
        if ($urandom_range(0, 9) == 0) begin
          send_word(random_word());
        end else begin
          run_sequence();
        end
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (book.pending() != 0) begin
      $display("%0t  results outstanding: expected 0, actual %0d", $time, book.pending());
      book.mismatches++;
    end
    if (book.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/gmmc_pkg.sv
rtl/core/gmmc_step.sv
rtl/core/gate_motor_move_controller.sv
tb/gate_motor_move_controller_tb.sv
